@@ sv/sbcr_pkg.sv @@
// ----------------------------------------------------------------------------
// sbcr_pkg
// Shared types, constants and saturating fixed-point helpers for the swept
// box collision response block.
// ----------------------------------------------------------------------------
package sbcr_pkg;

	localparam int COORD_W = 32;
	localparam int IN_W    = 32;
	localparam int EXT_W   = (COORD_W > IN_W) ? COORD_W : IN_W;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COORD_W:0]   wide_t;
	typedef logic signed [EXT_W-1:0]   ext_t;
	typedef logic signed [IN_W-1:0]    field_t;
	typedef logic signed [1:0]         normal_t;

	localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_W-1){1'b1}}});
	localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_W-1){1'b0}}});
	localparam coord_t COORD_ZERO = coord_t'(0);
	localparam ext_t   EXT_MAX   = ext_t'(COORD_MAX);
	localparam ext_t   EXT_MIN   = ext_t'(COORD_MIN);
	localparam wide_t  WIDE_MAX  = wide_t'(COORD_MAX);
	localparam wide_t  WIDE_MIN  = wide_t'(COORD_MIN);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEST = 1'b1;

	localparam normal_t NRM_NEG  = 2'sb11;
	localparam normal_t NRM_ZERO = 2'sb00;
	localparam normal_t NRM_POS  = 2'sb01;

	typedef enum logic [1:0] {
		SIDE_NX = 2'd0,
		SIDE_PX = 2'd1,
		SIDE_NY = 2'd2,
		SIDE_PY = 2'd3
	} side_t;

	function automatic coord_t clamp_in(field_t v);
		ext_t e;
		e = ext_t'(v);
		if (e > EXT_MAX) begin
			return COORD_MAX;
		end else if (e < EXT_MIN) begin
			return COORD_MIN;
		end else begin
			return coord_t'(e);
		end
	endfunction

	function automatic field_t to_field(coord_t v);
		ext_t e;
		e = ext_t'(v);
		return field_t'(e[IN_W-1:0]);
	endfunction

	function automatic coord_t sat_fit(wide_t s);
		if (s > WIDE_MAX) begin
			return COORD_MAX;
		end else if (s < WIDE_MIN) begin
			return COORD_MIN;
		end else begin
			return coord_t'(s);
		end
	endfunction

	function automatic coord_t sat_add(coord_t a, coord_t b);
		wide_t s;
		s = wide_t'(a) + wide_t'(b);
		return sat_fit(s);
	endfunction

	function automatic coord_t sat_sub(coord_t a, coord_t b);
		wide_t s;
		s = wide_t'(a) - wide_t'(b);
		return sat_fit(s);
	endfunction

	function automatic coord_t neg_part(coord_t v);
		return (v < COORD_ZERO) ? v : COORD_ZERO;
	endfunction

	function automatic coord_t pos_part(coord_t v);
		return (v > COORD_ZERO) ? v : COORD_ZERO;
	endfunction

endpackage

@@ sv/swept_box_collision_response.sv @@
// ----------------------------------------------------------------------------
// swept_box_collision_response
// Tests a moving 2D box against obstacle boxes: swept broad phase, then the
// Minkowski-expanded side of greatest distance gives normal and contact.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. busy is
//   always low, so one request can be issued every cycle.
//   op = load stores the mover box, velocity and reference position; it
//   produces no result. A test request that follows a load in the very next
//   cycle already sees the new mover.
//   op = test checks one obstacle box and velocity against the stored mover;
//   its result is driven with done high for exactly one cycle, after passing
//   through the input register, the expand stage and the result register, and
//   is taken at the rising edge that ends that cycle.
//   Throughput is one request per cycle: every stage advances each cycle and
//   nothing waits, so busy never rises.
//   Results are not held: the receiver must take them in that cycle.
//   arst_n low clears the mover to zero, empties the pipeline and drops done.
// ----------------------------------------------------------------------------
module swept_box_collision_response (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  op,
	input  sbcr_pkg::field_t      box_min_x,
	input  sbcr_pkg::field_t      box_min_y,
	input  sbcr_pkg::field_t      box_max_x,
	input  sbcr_pkg::field_t      box_max_y,
	input  sbcr_pkg::field_t      vel_x,
	input  sbcr_pkg::field_t      vel_y,
	input  sbcr_pkg::field_t      pos_x,
	input  sbcr_pkg::field_t      pos_y,
	output logic                  done,
	output logic                  overlap,
	output sbcr_pkg::normal_t     normal_x,
	output sbcr_pkg::normal_t     normal_y,
	output sbcr_pkg::field_t      contact_coord,
	output sbcr_pkg::field_t      side_distance
);

	logic accept;

	// input register
	logic              v_s1;
	logic              op_s1;
	sbcr_pkg::coord_t  bminx_s1, bminy_s1, bmaxx_s1, bmaxy_s1;
	sbcr_pkg::coord_t  velx_s1, vely_s1, posx_s1, posy_s1;

	// mover state, kept in the form the test path needs
	sbcr_pkg::coord_t  m_aminx_q, m_aminy_q, m_amaxx_q, m_amaxy_q;
	sbcr_pkg::coord_t  m_hxlo_q, m_hylo_q, m_hxhi_q, m_hyhi_q;
	sbcr_pkg::coord_t  m_px_q, m_py_q;
	logic              m_vxp_q, m_vxn_q, m_vyp_q, m_vyn_q;

	// expand stage
	logic              v_s2;
	sbcr_pkg::coord_t  sminx_s2, sminy_s2, smaxx_s2, smaxy_s2;
	sbcr_pkg::coord_t  exminx_s2, exminy_s2, exmaxx_s2, exmaxy_s2;
	sbcr_pkg::coord_t  aminx_s2, aminy_s2, amaxx_s2, amaxy_s2;
	sbcr_pkg::coord_t  px_s2, py_s2;
	logic              vxp_s2, vxn_s2, vyp_s2, vyn_s2;

	// result register
	logic              done_q;
	logic              overlap_q;
	sbcr_pkg::normal_t nx_q, ny_q;
	sbcr_pkg::field_t  contact_q, dist_q;

	logic              is_test_s1;
	logic              hit;
	sbcr_pkg::coord_t  d_nx, d_px, d_ny, d_py, best, contact;
	sbcr_pkg::side_t   side;
	sbcr_pkg::normal_t nx, ny;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op;
			bminx_s1 <= sbcr_pkg::clamp_in(box_min_x);
			bminy_s1 <= sbcr_pkg::clamp_in(box_min_y);
			bmaxx_s1 <= sbcr_pkg::clamp_in(box_max_x);
			bmaxy_s1 <= sbcr_pkg::clamp_in(box_max_y);
			velx_s1  <= sbcr_pkg::clamp_in(vel_x);
			vely_s1  <= sbcr_pkg::clamp_in(vel_y);
			posx_s1  <= sbcr_pkg::clamp_in(pos_x);
			posy_s1  <= sbcr_pkg::clamp_in(pos_y);
		end
	end

	// mover load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_aminx_q <= sbcr_pkg::COORD_ZERO;
			m_aminy_q <= sbcr_pkg::COORD_ZERO;
			m_amaxx_q <= sbcr_pkg::COORD_ZERO;
			m_amaxy_q <= sbcr_pkg::COORD_ZERO;
			m_hxlo_q  <= sbcr_pkg::COORD_ZERO;
			m_hylo_q  <= sbcr_pkg::COORD_ZERO;
			m_hxhi_q  <= sbcr_pkg::COORD_ZERO;
			m_hyhi_q  <= sbcr_pkg::COORD_ZERO;
			m_px_q    <= sbcr_pkg::COORD_ZERO;
			m_py_q    <= sbcr_pkg::COORD_ZERO;
			m_vxp_q   <= 1'b0;
			m_vxn_q   <= 1'b0;
			m_vyp_q   <= 1'b0;
			m_vyn_q   <= 1'b0;
		end else if (v_s1 && op_s1 == sbcr_pkg::OP_LOAD) begin
			m_aminx_q <= sbcr_pkg::sat_add(bminx_s1, sbcr_pkg::neg_part(velx_s1));
			m_aminy_q <= sbcr_pkg::sat_add(bminy_s1, sbcr_pkg::neg_part(vely_s1));
			m_amaxx_q <= sbcr_pkg::sat_add(bmaxx_s1, sbcr_pkg::pos_part(velx_s1));
			m_amaxy_q <= sbcr_pkg::sat_add(bmaxy_s1, sbcr_pkg::pos_part(vely_s1));
			m_hxlo_q  <= sbcr_pkg::sat_sub(bmaxx_s1, posx_s1);
			m_hylo_q  <= sbcr_pkg::sat_sub(bmaxy_s1, posy_s1);
			m_hxhi_q  <= sbcr_pkg::sat_sub(posx_s1, bminx_s1);
			m_hyhi_q  <= sbcr_pkg::sat_sub(posy_s1, bminy_s1);
			m_px_q    <= posx_s1;
			m_py_q    <= posy_s1;
			m_vxp_q   <= velx_s1 > sbcr_pkg::COORD_ZERO;
			m_vxn_q   <= velx_s1 < sbcr_pkg::COORD_ZERO;
			m_vyp_q   <= vely_s1 > sbcr_pkg::COORD_ZERO;
			m_vyn_q   <= vely_s1 < sbcr_pkg::COORD_ZERO;
		end
	end

	assign is_test_s1 = v_s1 && op_s1 == sbcr_pkg::OP_TEST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= is_test_s1;
		end
	end

	// sweep the obstacle and grow it around the mover position
	always_ff @(posedge clk) begin
		if (is_test_s1) begin
			sminx_s2  <= sbcr_pkg::sat_add(bminx_s1, sbcr_pkg::neg_part(velx_s1));
			sminy_s2  <= sbcr_pkg::sat_add(bminy_s1, sbcr_pkg::neg_part(vely_s1));
			smaxx_s2  <= sbcr_pkg::sat_add(bmaxx_s1, sbcr_pkg::pos_part(velx_s1));
			smaxy_s2  <= sbcr_pkg::sat_add(bmaxy_s1, sbcr_pkg::pos_part(vely_s1));
			exminx_s2 <= sbcr_pkg::sat_sub(bminx_s1, m_hxlo_q);
			exminy_s2 <= sbcr_pkg::sat_sub(bminy_s1, m_hylo_q);
			exmaxx_s2 <= sbcr_pkg::sat_add(bmaxx_s1, m_hxhi_q);
			exmaxy_s2 <= sbcr_pkg::sat_add(bmaxy_s1, m_hyhi_q);
			aminx_s2  <= m_aminx_q;
			aminy_s2  <= m_aminy_q;
			amaxx_s2  <= m_amaxx_q;
			amaxy_s2  <= m_amaxy_q;
			px_s2     <= m_px_q;
			py_s2     <= m_py_q;
			vxp_s2    <= m_vxp_q;
			vxn_s2    <= m_vxn_q;
			vyp_s2    <= m_vyp_q;
			vyn_s2    <= m_vyn_q;
		end
	end

	// strict overlap, side selection with later side winning ties
	always_comb begin
		hit = !(aminx_s2 >= smaxx_s2 || aminy_s2 >= smaxy_s2 ||
			sminx_s2 >= amaxx_s2 || sminy_s2 >= amaxy_s2);
		d_nx = sbcr_pkg::sat_sub(exminx_s2, px_s2);
		d_px = sbcr_pkg::sat_sub(px_s2, exmaxx_s2);
		d_ny = sbcr_pkg::sat_sub(exminy_s2, py_s2);
		d_py = sbcr_pkg::sat_sub(py_s2, exmaxy_s2);
		best = d_nx;
		side = sbcr_pkg::SIDE_NX;
		if (best <= d_px) begin
			best = d_px;
			side = sbcr_pkg::SIDE_PX;
		end
		if (best <= d_ny) begin
			best = d_ny;
			side = sbcr_pkg::SIDE_NY;
		end
		if (best <= d_py) begin
			best = d_py;
			side = sbcr_pkg::SIDE_PY;
		end
		unique case (side)
			sbcr_pkg::SIDE_NX: begin
				nx = sbcr_pkg::NRM_NEG;
				ny = sbcr_pkg::NRM_ZERO;
				contact = vxp_s2 ? exminx_s2 : px_s2;
			end
			sbcr_pkg::SIDE_PX: begin
				nx = sbcr_pkg::NRM_POS;
				ny = sbcr_pkg::NRM_ZERO;
				contact = vxn_s2 ? exmaxx_s2 : px_s2;
			end
			sbcr_pkg::SIDE_NY: begin
				nx = sbcr_pkg::NRM_ZERO;
				ny = sbcr_pkg::NRM_NEG;
				contact = vyp_s2 ? exminy_s2 : py_s2;
			end
			default: begin
				nx = sbcr_pkg::NRM_ZERO;
				ny = sbcr_pkg::NRM_POS;
				contact = vyn_s2 ? exmaxy_s2 : py_s2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			overlap_q <= hit;
			nx_q      <= hit ? nx : sbcr_pkg::NRM_ZERO;
			ny_q      <= hit ? ny : sbcr_pkg::NRM_ZERO;
			contact_q <= hit ? sbcr_pkg::to_field(contact) : sbcr_pkg::field_t'(0);
			dist_q    <= hit ? sbcr_pkg::to_field(best) : sbcr_pkg::field_t'(0);
		end
	end

	assign done          = done_q;
	assign overlap       = overlap_q;
	assign normal_x      = nx_q;
	assign normal_y      = ny_q;
	assign contact_coord = contact_q;
	assign side_distance = dist_q;

	a_test_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == sbcr_pkg::OP_TEST |-> ##3 done)
		else $error("test request lost its result");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == sbcr_pkg::OP_LOAD |-> ##3 !done)
		else $error("load request produced a result");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !overlap |-> normal_x == sbcr_pkg::NRM_ZERO &&
			normal_y == sbcr_pkg::NRM_ZERO && contact_coord == '0 && side_distance == '0)
		else $error("miss result carries nonzero fields");

	a_hit_one_axis: assert property (@(posedge clk) disable iff (!arst_n)
		done && overlap |-> (normal_x != sbcr_pkg::NRM_ZERO) != (normal_y != sbcr_pkg::NRM_ZERO))
		else $error("hit normal not on exactly one axis");

	a_done_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v_s2))
		else $error("result without a test in flight");

endmodule

@@ tb/sv/swept_box_collision_response_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swept_box_collision_response_tb
// Self-checking bench for the swept box collision block. A short table of
// requests covers touching and distant boxes, inverted boxes, every contact
// side and saturating extremes, followed by random mover scenes. Each test
// request is predicted in Q16.16 with saturation or taken from the table,
// and compared with the strobed result, field by field, in request order.
// ----------------------------------------------------------------------------
module swept_box_collision_response_tb;

	typedef struct packed {
		logic              overlap;
		sbcr_pkg::normal_t normal_x;
		sbcr_pkg::normal_t normal_y;
		sbcr_pkg::field_t  contact;
		sbcr_pkg::field_t  distance;
	} contact_t;

	typedef struct packed {
		logic             op;
		sbcr_pkg::field_t min_x;
		sbcr_pkg::field_t min_y;
		sbcr_pkg::field_t max_x;
		sbcr_pkg::field_t max_y;
		sbcr_pkg::field_t vel_x;
		sbcr_pkg::field_t vel_y;
		sbcr_pkg::field_t pos_x;
		sbcr_pkg::field_t pos_y;
		logic             fixed;
		contact_t         resp;
	} box_req_t;

	typedef struct {
		longint min_x, min_y, max_x, max_y, vel_x, vel_y, pos_x, pos_y;
	} mover_t;

	localparam sbcr_pkg::field_t F0   = 32'sh0;
	localparam sbcr_pkg::field_t ONE  = 32'sh00010000;
	localparam sbcr_pkg::field_t FMAX = 32'sh7fffffff;
	localparam sbcr_pkg::field_t FMIN = 32'sh80000000;
	localparam sbcr_pkg::field_t NEG1 = -32'sh1;
	localparam contact_t NO_CONTACT = '0;
	localparam int       NUM_DIRECTED = 23;
	localparam int       NUM_RANDOM   = 1430;
	localparam int       QUIET_LIMIT  = 2000;

	localparam box_req_t DIRECTED_REQS [NUM_DIRECTED] = '{
		'{sbcr_pkg::OP_TEST, F0, F0, F0, F0, F0, F0, F0, F0, 1'b1, NO_CONTACT},
		'{sbcr_pkg::OP_TEST, -ONE, -ONE, ONE, ONE, F0, F0, F0, F0, 1'b0, NO_CONTACT},
		'{sbcr_pkg::OP_LOAD, -ONE, -ONE, ONE, ONE, 2*ONE, F0, F0, F0, 1'b0, NO_CONTACT},
		'{sbcr_pkg::OP_TEST, 3*ONE, -ONE, 5*ONE, ONE, F0, F0, F0, F0, 1'b1, NO_CONTACT},
		'{sbcr_pkg::OP_TEST, 2*ONE, -ONE, 4*ONE, ONE, F0, F0, F0, F0, 1'b0, NO_CONTACT},
		'{sbcr_pkg::OP_LOAD, -ONE, -ONE, ONE, ONE, -2*ONE, F0, F0, F0, 1'b0, NO_CONTACT},
		'{sbcr_pkg::OP_TEST, -4*ONE, -ONE, -2*ONE, ONE, F0, F0, F0, F0, 1'b0, NO_CONTACT},
		'{sbcr_pkg::OP_LOAD, -ONE, -ONE, ONE, ONE, F0, 2*ONE, F0, F0, 1'b0, NO_CONTACT},
		'{sbcr_pkg::OP_TEST, -ONE, 2*ONE, ONE, 4*ONE, F0, F0, F0, F0, 1'b0, NO_CONTACT},
		'{sbcr_pkg::OP_LOAD, -ONE, -ONE, ONE, ONE, F0, -2*ONE, F0, F0, 1'b0, NO_CONTACT},
		'{sbcr_pkg::OP_TEST, -ONE, -4*ONE, ONE, -2*ONE, F0, F0, F0, F0, 1'b0, NO_CONTACT},
		'{sbcr_pkg::OP_TEST, 2*ONE, -ONE, 4*ONE, ONE, -3*ONE, F0, F0, F0, 1'b0,
			NO_CONTACT},
		'{sbcr_pkg::OP_TEST, 10*ONE, 10*ONE, 12*ONE, 12*ONE, F0, F0, F0, F0, 1'b1,
			NO_CONTACT},
		'{sbcr_pkg::OP_LOAD, ONE, ONE, -ONE, -ONE, F0, F0, F0, F0, 1'b0, NO_CONTACT},
		'{sbcr_pkg::OP_TEST, -2*ONE, -2*ONE, 2*ONE, 2*ONE, F0, F0, F0, F0, 1'b0,
			NO_CONTACT},
		'{sbcr_pkg::OP_TEST, 2*ONE, 2*ONE, -2*ONE, -2*ONE, F0, F0, F0, F0, 1'b1,
			NO_CONTACT},
		'{sbcr_pkg::OP_LOAD, FMIN, FMIN, FMAX, FMAX, FMAX, FMIN, FMAX, FMIN, 1'b0,
			NO_CONTACT},
		'{sbcr_pkg::OP_TEST, FMIN, FMIN, FMAX, FMAX, FMIN, FMAX, F0, F0, 1'b0, NO_CONTACT},
		'{sbcr_pkg::OP_TEST, F0, F0, ONE, ONE, F0, F0, F0, F0, 1'b0, NO_CONTACT},
		'{sbcr_pkg::OP_LOAD, FMAX, FMAX, FMIN, FMIN, FMIN, FMIN, FMIN, FMAX, 1'b0,
			NO_CONTACT},
		'{sbcr_pkg::OP_TEST, FMIN, FMIN, FMAX, FMAX, FMAX, FMAX, F0, F0, 1'b0, NO_CONTACT},
		'{sbcr_pkg::OP_LOAD, NEG1, NEG1, NEG1, NEG1, NEG1, NEG1, NEG1, NEG1, 1'b0,
			NO_CONTACT},
		'{sbcr_pkg::OP_TEST, NEG1, NEG1, NEG1, NEG1, NEG1, NEG1, NEG1, NEG1, 1'b0,
			NO_CONTACT}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              op;
	sbcr_pkg::field_t  box_min_x, box_min_y, box_max_x, box_max_y;
	sbcr_pkg::field_t  vel_x, vel_y, pos_x, pos_y;
	logic              done;
	logic              overlap;
	sbcr_pkg::normal_t normal_x, normal_y;
	sbcr_pkg::field_t  contact_coord, side_distance;

	logic     req_fixed;
	contact_t req_resp;

	contact_t         pending_contacts [$];
	mover_t           mover;
	int               mismatches = 0;
	int               quiet_cycles = 0;
	int               idle_pct = 10;
	sbcr_pkg::field_t scene_x = 0, scene_y = 0;
	int               span = 16;

	swept_box_collision_response u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.box_min_x     (box_min_x),
		.box_min_y     (box_min_y),
		.box_max_x     (box_max_x),
		.box_max_y     (box_max_y),
		.vel_x         (vel_x),
		.vel_y         (vel_y),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.done          (done),
		.overlap       (overlap),
		.normal_x      (normal_x),
		.normal_y      (normal_y),
		.contact_coord (contact_coord),
		.side_distance (side_distance)
	);

	always #5 clk = ~clk;

	function automatic longint clip32(longint v);
		if (v > longint'(FMAX)) return longint'(FMAX);
		if (v < longint'(FMIN)) return longint'(FMIN);
		return v;
	endfunction

	function automatic longint add_sat(longint a, longint b);
		return clip32(a + b);
	endfunction

	function automatic longint sub_sat(longint a, longint b);
		return clip32(a - b);
	endfunction

	function automatic contact_t resolve_contact(sbcr_pkg::field_t bx0,
			sbcr_pkg::field_t by0, sbcr_pkg::field_t bx1, sbcr_pkg::field_t by1,
			sbcr_pkg::field_t vx, sbcr_pkg::field_t vy);
		longint ax0, ay0, ax1, ay1, sx0, sy0, sx1, sy1;
		longint ex0, ey0, ex1, ey1, best, d, pt;
		sbcr_pkg::side_t side;
		contact_t r;
		r = NO_CONTACT;
		// swept bounds of both boxes
		ax0 = add_sat(mover.min_x, mover.vel_x < 0 ? mover.vel_x : 0);
		ay0 = add_sat(mover.min_y, mover.vel_y < 0 ? mover.vel_y : 0);
		ax1 = add_sat(mover.max_x, mover.vel_x > 0 ? mover.vel_x : 0);
		ay1 = add_sat(mover.max_y, mover.vel_y > 0 ? mover.vel_y : 0);
		sx0 = add_sat(longint'(bx0), vx < 0 ? longint'(vx) : 0);
		sy0 = add_sat(longint'(by0), vy < 0 ? longint'(vy) : 0);
		sx1 = add_sat(longint'(bx1), vx > 0 ? longint'(vx) : 0);
		sy1 = add_sat(longint'(by1), vy > 0 ? longint'(vy) : 0);
		if (ax0 >= sx1 || ay0 >= sy1 || sx0 >= ax1 || sy0 >= ay1) begin
			return r;
		end
		// obstacle grown around the mover reference point
		ex0 = sub_sat(longint'(bx0), sub_sat(mover.max_x, mover.pos_x));
		ey0 = sub_sat(longint'(by0), sub_sat(mover.max_y, mover.pos_y));
		ex1 = add_sat(longint'(bx1), sub_sat(mover.pos_x, mover.min_x));
		ey1 = add_sat(longint'(by1), sub_sat(mover.pos_y, mover.min_y));
		best = sub_sat(ex0, mover.pos_x);
		side = sbcr_pkg::SIDE_NX;
		d = sub_sat(mover.pos_x, ex1);
		if (d >= best) begin
			best = d;
			side = sbcr_pkg::SIDE_PX;
		end
		d = sub_sat(ey0, mover.pos_y);
		if (d >= best) begin
			best = d;
			side = sbcr_pkg::SIDE_NY;
		end
		d = sub_sat(mover.pos_y, ey1);
		if (d >= best) begin
			best = d;
			side = sbcr_pkg::SIDE_PY;
		end
		case (side)
			sbcr_pkg::SIDE_NX: begin
				r.normal_x = sbcr_pkg::NRM_NEG;
				pt = (mover.vel_x > 0) ? ex0 : mover.pos_x;
			end
			sbcr_pkg::SIDE_PX: begin
				r.normal_x = sbcr_pkg::NRM_POS;
				pt = (mover.vel_x < 0) ? ex1 : mover.pos_x;
			end
			sbcr_pkg::SIDE_NY: begin
				r.normal_y = sbcr_pkg::NRM_NEG;
				pt = (mover.vel_y > 0) ? ey0 : mover.pos_y;
			end
			default: begin
				r.normal_y = sbcr_pkg::NRM_POS;
				pt = (mover.vel_y < 0) ? ey1 : mover.pos_y;
			end
		endcase
		r.overlap = 1'b1;
		r.contact = sbcr_pkg::field_t'(pt);
		r.distance = sbcr_pkg::field_t'(best);
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// results are checked before new requests are queued
	always @(posedge clk) begin
		contact_t want;
		if (arst_n && done) begin
			if (pending_contacts.size() == 0) begin
				mismatches++;
				$display("%0t: result with no request pending, expected none, actual %0h",
					$time, {overlap, normal_x, normal_y, contact_coord, side_distance});
			end else begin
				want = pending_contacts.pop_front();
				check_field("overlap", 32'(want.overlap), 32'(overlap));
				check_field("normal_x", 32'(want.normal_x), 32'(normal_x));
				check_field("normal_y", 32'(want.normal_y), 32'(normal_y));
				check_field("contact_coord", want.contact, contact_coord);
				check_field("side_distance", want.distance, side_distance);
			end
		end
		if (arst_n && start && !busy) begin
			if (op == sbcr_pkg::OP_LOAD) begin
				mover.min_x = longint'(box_min_x);
				mover.min_y = longint'(box_min_y);
				mover.max_x = longint'(box_max_x);
				mover.max_y = longint'(box_max_y);
				mover.vel_x = longint'(vel_x);
				mover.vel_y = longint'(vel_y);
				mover.pos_x = longint'(pos_x);
				mover.pos_y = longint'(pos_y);
			end else if (req_fixed) begin
				pending_contacts.push_back(req_resp);
			end else begin
				pending_contacts.push_back(resolve_contact(box_min_x, box_min_y,
					box_max_x, box_max_y, vel_x, vel_y));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && ((start && !busy) || done)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic sbcr_pkg::field_t extreme_value();
		case ($urandom_range(6))
			0: return FMIN;
			1: return FMAX;
			2: return F0;
			3: return NEG1;
			4: return ONE;
			5: return FMIN + 1;
			default: return FMAX - 1;
		endcase
	endfunction

	function automatic sbcr_pkg::field_t near(sbcr_pkg::field_t c);
		int unsigned r;
		r = $urandom_range(19);
		if (r == 0) return extreme_value();
		if (r == 1) return sbcr_pkg::field_t'($urandom);
		return c + sbcr_pkg::field_t'($urandom_range(0, 2 << span))
			- sbcr_pkg::field_t'(1 << span);
	endfunction

	function automatic sbcr_pkg::field_t extent();
		sbcr_pkg::field_t s;
		s = sbcr_pkg::field_t'($urandom_range(0, 1 << span));
		if ($urandom_range(9) == 0) begin
			s = -s;
		end
		return s;
	endfunction

	task automatic random_req(output box_req_t r);
		r = '0;
		if ($urandom_range(99) < 10) begin
			// raw noise over every field
			r.op = 1'($urandom);
			r.min_x = sbcr_pkg::field_t'($urandom);
			r.min_y = sbcr_pkg::field_t'($urandom);
			r.max_x = sbcr_pkg::field_t'($urandom);
			r.max_y = sbcr_pkg::field_t'($urandom);
			r.vel_x = sbcr_pkg::field_t'($urandom);
			r.vel_y = sbcr_pkg::field_t'($urandom);
			r.pos_x = sbcr_pkg::field_t'($urandom);
			r.pos_y = sbcr_pkg::field_t'($urandom);
			return;
		end
		r.op = ($urandom_range(99) < 12) ? sbcr_pkg::OP_LOAD : sbcr_pkg::OP_TEST;
		if (r.op == sbcr_pkg::OP_LOAD && $urandom_range(3) == 0) begin
			span = $urandom_range(4, 24);
			if ($urandom_range(4) == 0) begin
				scene_x = sbcr_pkg::field_t'($urandom);
				scene_y = sbcr_pkg::field_t'($urandom);
			end else begin
				scene_x = sbcr_pkg::field_t'($urandom_range(0, 1 << 25))
					- sbcr_pkg::field_t'(1 << 24);
				scene_y = sbcr_pkg::field_t'($urandom_range(0, 1 << 25))
					- sbcr_pkg::field_t'(1 << 24);
			end
		end
		r.min_x = near(scene_x);
		r.min_y = near(scene_y);
		r.max_x = r.min_x + extent();
		r.max_y = r.min_y + extent();
		r.vel_x = near(F0);
		r.vel_y = near(F0);
		if (r.op == sbcr_pkg::OP_LOAD) begin
			r.pos_x = near(scene_x);
			r.pos_y = near(scene_y);
		end else begin
			r.pos_x = sbcr_pkg::field_t'($urandom);
			r.pos_y = sbcr_pkg::field_t'($urandom);
		end
	endtask

	// called right after a rising edge; returns right after the accepting edge
	task automatic issue(box_req_t r);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			op <= 1'($urandom);
			box_min_x <= sbcr_pkg::field_t'($urandom);
			box_min_y <= sbcr_pkg::field_t'($urandom);
			box_max_x <= sbcr_pkg::field_t'($urandom);
			box_max_y <= sbcr_pkg::field_t'($urandom);
			vel_x <= sbcr_pkg::field_t'($urandom);
			vel_y <= sbcr_pkg::field_t'($urandom);
			pos_x <= sbcr_pkg::field_t'($urandom);
			pos_y <= sbcr_pkg::field_t'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		op <= r.op;
		box_min_x <= r.min_x;
		box_min_y <= r.min_y;
		box_max_x <= r.max_x;
		box_max_y <= r.max_y;
		vel_x <= r.vel_x;
		vel_y <= r.vel_y;
		pos_x <= r.pos_x;
		pos_y <= r.pos_y;
		req_fixed <= r.fixed;
		req_resp <= r.resp;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_contacts.size() != 0);
	endtask

	initial begin
		box_req_t r;
		arst_n = 1'b0;
		start = 1'b0;
		op = sbcr_pkg::OP_LOAD;
		{box_min_x, box_min_y, box_max_x, box_max_y} = '0;
		{vel_x, vel_y, pos_x, pos_y} = '0;
		req_fixed = 1'b0;
		req_resp = NO_CONTACT;
		mover = '{default: 0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			issue(DIRECTED_REQS[i]);
		end
		drain();
		for (int i = 0; i < NUM_RANDOM; i++) begin
			idle_pct = (i >= 500 && i < 800) ? 0 : 10;
			if (i == 1000) begin
				drain();
			end
			random_req(r);
			issue(r);
		end
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_contacts.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/sbcr_pkg.sv
sv/swept_box_collision_response.sv
tb/sv/swept_box_collision_response_tb.sv
